FILE: sv/mch_pkg.sv
// Shared constants, command and register codes, and the arctangent table for the
// magnetometer calibration and heading block. No dependencies.
`default_nettype none

package mch_pkg;

    // Default values for the top-level parameters.
    localparam int CORDIC_STEPS_DEF      = 16;
    localparam int GAIN_FRAC_BITS_DEF    = 24;
    localparam int HEADING_FRAC_BITS_DEF = 6;

    // Field widths fixed by the interface.
    localparam int RAW_W     = 16;
    localparam int CORR_W    = 18;
    localparam int CORR_FRAC = 14;
    localparam int CNT_W     = 16;
    localparam int FUNC_W    = 2;

    // Configuration port.
    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;
    localparam int REG_IDX_W = ADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_CAL_SAMPLE_COUNT = 1'b0;
    localparam int CAL_COUNT_RESET = 500;

    // Command codes.
    localparam logic [FUNC_W-1:0] FUNC_START   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_CAL     = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_MEASURE = 2'd2;

    // Default gain is one over this many counts per gauss.
    localparam int GAIN_DIVISOR = 1090;

    // Angle arithmetic in degrees with sixteen fraction bits.
    localparam int ANG_FRAC      = 16;
    localparam int PRESCALE_BITS = 8;
    localparam int ATAN_W        = 23;
    localparam int ATAN_IDX_W    = 5;
    localparam int Z_W           = 26;
    localparam int FULL_TURN     = 360;
    localparam int QUARTER_TURN  = 90;

    // Saturation limits of the corrected axes.
    localparam logic signed [CORR_W-1:0] CORR_POS_MAX = {1'b0, {(CORR_W-1){1'b1}}};
    localparam logic signed [CORR_W-1:0] CORR_NEG_MIN = {1'b1, {(CORR_W-1){1'b0}}};

    // atan(2^-i) in degrees with sixteen fraction bits.
    function automatic logic [ATAN_W-1:0] atan_deg(input logic [ATAN_IDX_W-1:0] idx);
        case (idx)
            5'd0:    return 23'd2949120;
            5'd1:    return 23'd1740967;
            5'd2:    return 23'd919879;
            5'd3:    return 23'd466945;
            5'd4:    return 23'd234379;
            5'd5:    return 23'd117304;
            5'd6:    return 23'd58666;
            5'd7:    return 23'd29335;
            5'd8:    return 23'd14668;
            5'd9:    return 23'd7334;
            5'd10:   return 23'd3667;
            5'd11:   return 23'd1833;
            5'd12:   return 23'd917;
            5'd13:   return 23'd458;
            5'd14:   return 23'd229;
            5'd15:   return 23'd115;
            5'd16:   return 23'd57;
            5'd17:   return 23'd29;
            5'd18:   return 23'd14;
            5'd19:   return 23'd7;
            5'd20:   return 23'd4;
            5'd21:   return 23'd2;
            5'd22:   return 23'd1;
            default: return '0;
        endcase
    endfunction

endpackage

`default_nettype wire

FILE: sv/mch_div.sv
// Restoring divider that produces one quotient bit per cycle, MSB first.
// Depends on nothing beyond its parameters.
`default_nettype none

module mch_div #(
    parameter int NUM_W = 26,
    parameter int DEN_W = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] numer,
    input  logic [DEN_W-1:0] denom,
    output logic             done,
    output logic [NUM_W-1:0] quot
);

    localparam int CNT_W = $clog2(NUM_W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0] num_reg, num_next;
    logic [NUM_W-1:0] quot_reg, quot_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;

    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   trial;

    // One step: bring down the next numerator bit and try the subtraction.
    assign shifted = {rem_reg, num_reg[NUM_W-1]};
    assign trial   = shifted - {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NUM_W - 1);
            num_next  = numer;
            quot_next = '0;
            rem_next  = '0;
            den_next  = denom;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[NUM_W-2:0], 1'b0};
            if (!trial[DEN_W])
            begin
                rem_next  = trial[DEN_W-1:0];
                quot_next = {quot_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = shifted[DEN_W-1:0];
                quot_next = {quot_reg[NUM_W-2:0], 1'b0};
            end
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    // Control state is reset; the datapath registers are loaded on start.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        num_reg  <= num_next;
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

`default_nettype wire

FILE: sv/mch_cordic.sv
// Iterative vectoring CORDIC giving the heading atan2(y, x) in 0 to 360 degrees.
// Depends on mch_pkg for widths and the arctangent table.
`default_nettype none

module mch_cordic #(
    parameter int STEPS             = mch_pkg::CORDIC_STEPS_DEF,
    parameter int HEADING_FRAC_BITS = mch_pkg::HEADING_FRAC_BITS_DEF,
    parameter int HEAD_W            = 15
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic signed [mch_pkg::CORR_W-1:0] x_in,
    input  logic signed [mch_pkg::CORR_W-1:0] y_in,
    output logic                             done,
    output logic [HEAD_W-1:0]                heading
);

    localparam int CORR_W = mch_pkg::CORR_W;
    localparam int PRE_W  = mch_pkg::PRESCALE_BITS;
    localparam int CW     = CORR_W + PRE_W + 3;
    localparam int Z_W    = mch_pkg::Z_W;
    localparam int ITER_W = $clog2(STEPS);
    localparam int RSH    = mch_pkg::ANG_FRAC - HEADING_FRAC_BITS;

    localparam logic signed [Z_W-1:0] QUARTER  =
        Z_W'(mch_pkg::QUARTER_TURN << mch_pkg::ANG_FRAC);
    localparam logic signed [Z_W-1:0] FULL     =
        Z_W'(mch_pkg::FULL_TURN << mch_pkg::ANG_FRAC);
    localparam logic signed [Z_W-1:0] HALF_LSB = Z_W'(1 << (RSH - 1));
    localparam logic signed [Z_W-1:0] LIM      =
        Z_W'(mch_pkg::FULL_TURN << HEADING_FRAC_BITS);

    logic signed [CW-1:0]  x_reg, x_next;
    logic signed [CW-1:0]  y_reg, y_next;
    logic signed [Z_W-1:0] z_reg, z_next;
    logic [ITER_W-1:0]     iter_reg, iter_next;
    logic                  busy_reg, busy_next;
    logic                  fin_reg, fin_next;
    logic                  done_reg, done_next;
    logic [HEAD_W-1:0]     head_reg, head_next;

    logic signed [CW-1:0]  xs;
    logic signed [CW-1:0]  ys;
    logic signed [CW-1:0]  dx;
    logic signed [CW-1:0]  dy;
    logic signed [Z_W-1:0] at;
    logic signed [Z_W-1:0] zw;
    logic signed [Z_W-1:0] hr;

    // Inputs scaled up for headroom in the shifted terms.
    assign xs = {{(CW-CORR_W-PRE_W){x_in[CORR_W-1]}}, x_in, {PRE_W{1'b0}}};
    assign ys = {{(CW-CORR_W-PRE_W){y_in[CORR_W-1]}}, y_in, {PRE_W{1'b0}}};

    // Shifted terms and the angle of the current micro-rotation.
    assign dx = y_reg >>> iter_reg;
    assign dy = x_reg >>> iter_reg;
    assign at = Z_W'(mch_pkg::atan_deg(mch_pkg::ATAN_IDX_W'(iter_reg)));

    // Wrap a negative angle by a full turn, then round to the output step.
    always_comb
    begin
        zw = (z_reg < 0) ? z_reg + FULL : z_reg;
        if (zw < 0)
        begin
            zw = '0;
        end
        hr = (zw + HALF_LSB) >>> RSH;
        if (hr >= LIM)
        begin
            hr = hr - LIM;
        end
    end

    always_comb
    begin
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        iter_next = iter_reg;
        busy_next = busy_reg;
        fin_next  = fin_reg;
        done_next = 1'b0;
        head_next = head_reg;
        if (start)
        begin
            if (x_in == '0 && y_in == '0)
            begin
                // A zero vector has heading zero.
                head_next = '0;
                done_next = 1'b1;
            end
            else
            begin
                // Bring the vector into the right half-plane first.
                iter_next = '0;
                busy_next = 1'b1;
                if (xs < 0)
                begin
                    if (ys >= 0)
                    begin
                        x_next = ys;
                        y_next = -xs;
                        z_next = QUARTER;
                    end
                    else
                    begin
                        x_next = -ys;
                        y_next = xs;
                        z_next = -QUARTER;
                    end
                end
                else
                begin
                    x_next = xs;
                    y_next = ys;
                    z_next = '0;
                end
            end
        end
        else if (busy_reg)
        begin
            if (y_reg > 0)
            begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + at;
            end
            else
            begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - at;
            end
            if (iter_reg == ITER_W'(STEPS - 1))
            begin
                busy_next = 1'b0;
                fin_next  = 1'b1;
            end
            else
            begin
                iter_next = iter_reg + 1'b1;
            end
        end
        else if (fin_reg)
        begin
            head_next = hr[HEAD_W-1:0];
            fin_next  = 1'b0;
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        iter_reg <= iter_next;
        head_reg <= head_next;
    end

    assign done    = done_reg;
    assign heading = head_reg;

endmodule

`default_nettype wire

FILE: sv/magnetometer_calibrate_heading.sv
// Top level of the magnetometer hard-iron calibration and heading block.
// Depends on mch_pkg, mch_div and mch_cordic.
//
// One item is worked on at a time; the input stalls from the transfer until the
// result has been loaded into the output register, which then waits on its own.
// Start, unused commands and calibration samples that do not complete a round
// go straight from the command decode to the output stage. A sample that
// completes calibration runs the bit-serial divider once per axis, except for
// an axis of zero span. A measure item runs the bit-serial gain multiplier, a
// rounding step and then the CORDIC, one iteration per cycle; a failed read
// skips the arithmetic.
// cal_sample_count is the only register, at byte address 0.
`default_nettype none

module magnetometer_calibrate_heading #(
    parameter int CORDIC_STEPS      = mch_pkg::CORDIC_STEPS_DEF,
    parameter int GAIN_FRAC_BITS    = mch_pkg::GAIN_FRAC_BITS_DEF,
    parameter int HEADING_FRAC_BITS = mch_pkg::HEADING_FRAC_BITS_DEF,
    localparam int HEAD_W = $clog2(mch_pkg::FULL_TURN << HEADING_FRAC_BITS)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Configuration port.
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mch_pkg::ADDR_W-1:0]        paddr,
    input  logic [mch_pkg::DATA_W-1:0]        pwdata,
    output logic [mch_pkg::DATA_W-1:0]        prdata,
    output logic                              pready,
    // Input channel.
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [mch_pkg::FUNC_W-1:0]        func,
    input  logic                              read_ok,
    input  logic signed [mch_pkg::RAW_W-1:0]  raw_x,
    input  logic signed [mch_pkg::RAW_W-1:0]  raw_z,
    input  logic signed [mch_pkg::RAW_W-1:0]  raw_y,
    // Output channel.
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [mch_pkg::CORR_W-1:0] corr_x,
    output logic signed [mch_pkg::CORR_W-1:0] corr_y,
    output logic signed [mch_pkg::CORR_W-1:0] corr_z,
    output logic [HEAD_W-1:0]                 heading_deg,
    output logic                              cal_done,
    output logic                              cal_error,
    output logic                              sat_flag
);

    localparam int RAW_W     = mch_pkg::RAW_W;
    localparam int CORR_W    = mch_pkg::CORR_W;
    localparam int CNT_W     = mch_pkg::CNT_W;
    localparam int GAIN_W    = GAIN_FRAC_BITS + 2;
    localparam int DIFF_W    = RAW_W + 1;
    localparam int MAG_W     = DIFF_W;
    localparam int ACC_W     = MAG_W + GAIN_W;
    localparam int RND_SH    = GAIN_FRAC_BITS - mch_pkg::CORR_FRAC;
    localparam int BIT_CNT_W = $clog2(MAG_W);

    localparam logic [1:0] AXIS_X    = 2'd0;
    localparam logic [1:0] AXIS_Y    = 2'd1;
    localparam logic [1:0] AXIS_Z    = 2'd2;

    localparam logic [GAIN_W-1:0] DEFAULT_GAIN = GAIN_W'(
        ((64'd1 << GAIN_FRAC_BITS) + 64'(mch_pkg::GAIN_DIVISOR / 2))
        / 64'(mch_pkg::GAIN_DIVISOR));
    localparam logic [GAIN_W-1:0] GAIN_NUM   = GAIN_W'(64'd2 << GAIN_FRAC_BITS);
    localparam logic [ACC_W:0]    ROUND_HALF = (ACC_W+1)'(64'd1 << (RND_SH - 1));
    localparam logic [ACC_W:0]    POS_LIMIT  = (ACC_W+1)'((64'd1 << (CORR_W - 1)) - 64'd1);
    localparam logic [ACC_W:0]    NEG_LIMIT  = (ACC_W+1)'(64'd1 << (CORR_W - 1));

    typedef enum logic [8:0] {
        ST_IDLE       = 9'b000000001,
        ST_EXEC       = 9'b000000010,
        ST_SPAN       = 9'b000000100,
        ST_DIVIDE     = 9'b000001000,
        ST_MUL        = 9'b000010000,
        ST_ROUND      = 9'b000100000,
        ST_HEAD_START = 9'b001000000,
        ST_CORDIC     = 9'b010000000,
        ST_EMIT       = 9'b100000000
    } state_t;

    state_t                       state_reg, state_next;
    logic [CNT_W-1:0]             cal_count_reg, cal_count_next;
    logic [CNT_W-1:0]             samples_reg, samples_next;

    // Item held while it is worked on.
    logic [mch_pkg::FUNC_W-1:0]   item_func_reg, item_func_next;
    logic                         item_ok_reg, item_ok_next;
    logic signed [RAW_W-1:0]      item_v_reg [3];
    logic signed [RAW_W-1:0]      item_v_next [3];

    // Calibration state.
    logic signed [RAW_W-1:0]      min_reg [3];
    logic signed [RAW_W-1:0]      min_next [3];
    logic signed [RAW_W-1:0]      max_reg [3];
    logic signed [RAW_W-1:0]      max_next [3];
    logic signed [RAW_W-1:0]      offset_reg [3];
    logic signed [RAW_W-1:0]      offset_next [3];
    logic [GAIN_W-1:0]            gain_reg [3];
    logic [GAIN_W-1:0]            gain_next [3];
    logic [1:0]                   axis_reg, axis_next;

    // Bit-serial multiplier.
    logic [MAG_W-1:0]             mag_reg [3];
    logic [MAG_W-1:0]             mag_next [3];
    logic                         neg_reg [3];
    logic                         neg_next [3];
    logic [ACC_W-1:0]             acc_reg [3];
    logic [ACC_W-1:0]             acc_next [3];
    logic [BIT_CNT_W-1:0]         bit_cnt_reg, bit_cnt_next;

    // Result being assembled and the output register.
    logic signed [CORR_W-1:0]     res_corr_reg [3];
    logic signed [CORR_W-1:0]     res_corr_next [3];
    logic [HEAD_W-1:0]            res_head_reg, res_head_next;
    logic                         res_done_reg, res_done_next;
    logic                         res_err_reg, res_err_next;
    logic                         res_sat_reg, res_sat_next;

    logic                         out_valid_reg, out_valid_next;
    logic signed [CORR_W-1:0]     out_corr_reg [3];
    logic signed [CORR_W-1:0]     out_corr_next [3];
    logic [HEAD_W-1:0]            out_head_reg, out_head_next;
    logic                         out_done_reg, out_done_next;
    logic                         out_err_reg, out_err_next;
    logic                         out_sat_reg, out_sat_next;

    // Helpers.
    logic                         cfg_write;
    logic                         cfg_hit;
    logic [CNT_W-1:0]             samples_inc;
    logic                         round_complete;
    logic signed [DIFF_W-1:0]     axis_sum;
    logic signed [DIFF_W-1:0]     axis_span;
    logic signed [DIFF_W-1:0]     diff [3];
    logic                         div_start;
    logic                         div_done;
    logic [GAIN_W-1:0]            div_quot;
    logic [GAIN_W-1:0]            div_numer;
    logic                         cordic_start;
    logic                         cordic_done;
    logic [HEAD_W-1:0]            cordic_heading;
    logic                         out_free;
    logic [CORR_W:0]              rounded [3];

    // Round the product half away from zero and saturate to Q3.14; the top bit
    // of the result tells whether the value was clamped.
    function automatic logic [CORR_W:0] round_sat(input logic [ACC_W-1:0] acc,
                                                  input logic neg);
        logic [ACC_W:0] r;
        r = ({1'b0, acc} + ROUND_HALF) >> RND_SH;
        if (neg)
        begin
            if (r > NEG_LIMIT)
            begin
                return {1'b1, mch_pkg::CORR_NEG_MIN};
            end
            return {1'b0, -r[CORR_W-1:0]};
        end
        if (r > POS_LIMIT)
        begin
            return {1'b1, mch_pkg::CORR_POS_MAX};
        end
        return {1'b0, r[CORR_W-1:0]};
    endfunction

    // Configuration port: one register, always ready.
    assign pready    = 1'b1;
    assign cfg_hit   = (paddr[mch_pkg::ADDR_W-1:2] == mch_pkg::REG_CAL_SAMPLE_COUNT);
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = cfg_hit ? {{(mch_pkg::DATA_W-CNT_W){1'b0}}, cal_count_reg} : '0;

    // Sample count and completion of a calibration round.
    assign samples_inc    = samples_reg + 1'b1;
    assign round_complete = (samples_inc >= cal_count_reg) || (samples_inc == '0);

    // Sum of the extremes and span of the axis that the sequencer is on.
    assign axis_sum  = {min_reg[axis_reg][RAW_W-1], min_reg[axis_reg]}
                     + {max_reg[axis_reg][RAW_W-1], max_reg[axis_reg]};
    assign axis_span = {max_reg[axis_reg][RAW_W-1], max_reg[axis_reg]}
                     - {min_reg[axis_reg][RAW_W-1], min_reg[axis_reg]};
    assign div_numer = GAIN_NUM + GAIN_W'(axis_span[RAW_W-1:1]);

    // Offset-corrected axes and the rounded products.
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            diff[a]    = {item_v_reg[a][RAW_W-1], item_v_reg[a]}
                       - {offset_reg[a][RAW_W-1], offset_reg[a]};
            rounded[a] = round_sat(acc_reg[a], neg_reg[a]);
        end
    end

    assign out_free = !out_valid_reg || !out_stall;

    // Sequencer and datapath.
    always_comb
    begin
        state_next     = state_reg;
        cal_count_next = cal_count_reg;
        samples_next   = samples_reg;
        item_func_next = item_func_reg;
        item_ok_next   = item_ok_reg;
        item_v_next    = item_v_reg;
        min_next       = min_reg;
        max_next       = max_reg;
        offset_next    = offset_reg;
        gain_next      = gain_reg;
        axis_next      = axis_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        acc_next       = acc_reg;
        bit_cnt_next   = bit_cnt_reg;
        res_corr_next  = res_corr_reg;
        res_head_next  = res_head_reg;
        res_done_next  = res_done_reg;
        res_err_next   = res_err_reg;
        res_sat_next   = res_sat_reg;
        out_valid_next = out_valid_reg;
        out_corr_next  = out_corr_reg;
        out_head_next  = out_head_reg;
        out_done_next  = out_done_reg;
        out_err_next   = out_err_reg;
        out_sat_next   = out_sat_reg;
        div_start      = 1'b0;
        cordic_start   = 1'b0;

        if (cfg_write && cfg_hit)
        begin
            cal_count_next = pwdata[CNT_W-1:0];
        end

        // The output register empties on a completed transfer.
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    item_func_next = func;
                    item_ok_next   = read_ok;
                    item_v_next[0] = read_ok ? raw_x : '0;
                    item_v_next[1] = read_ok ? raw_y : '0;
                    item_v_next[2] = read_ok ? raw_z : '0;
                    state_next     = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                for (int a = 0; a < 3; a++)
                begin
                    res_corr_next[a] = '0;
                end
                res_head_next = '0;
                res_done_next = 1'b0;
                res_err_next  = 1'b0;
                res_sat_next  = 1'b0;
                state_next    = ST_EMIT;
                case (item_func_reg)
                    mch_pkg::FUNC_START:
                    begin
                        samples_next = '0;
                        for (int a = 0; a < 3; a++)
                        begin
                            min_next[a]    = '0;
                            max_next[a]    = '0;
                            offset_next[a] = '0;
                            gain_next[a]   = DEFAULT_GAIN;
                        end
                    end
                    mch_pkg::FUNC_CAL:
                    begin
                        // The first sample of a round loads both extremes.
                        for (int a = 0; a < 3; a++)
                        begin
                            if (samples_reg == '0 || item_v_reg[a] < min_reg[a])
                            begin
                                min_next[a] = item_v_reg[a];
                            end
                            if (samples_reg == '0 || item_v_reg[a] > max_reg[a])
                            begin
                                max_next[a] = item_v_reg[a];
                            end
                        end
                        samples_next = samples_inc;
                        if (round_complete)
                        begin
                            samples_next  = '0;
                            res_done_next = 1'b1;
                            axis_next     = AXIS_X;
                            state_next    = ST_SPAN;
                        end
                    end
                    mch_pkg::FUNC_MEASURE:
                    begin
                        if (item_ok_reg)
                        begin
                            for (int a = 0; a < 3; a++)
                            begin
                                neg_next[a] = diff[a][DIFF_W-1];
                                mag_next[a] = diff[a][DIFF_W-1] ? MAG_W'(-diff[a])
                                                                : MAG_W'(diff[a]);
                                acc_next[a] = '0;
                            end
                            bit_cnt_next = BIT_CNT_W'(MAG_W - 1);
                            state_next   = ST_MUL;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_SPAN:
            begin
                // Offset is the floored midpoint; a zero span keeps the gain.
                offset_next[axis_reg] = axis_sum[DIFF_W-1:1];
                if (axis_span == '0)
                begin
                    res_err_next = 1'b1;
                    if (axis_reg == AXIS_Z)
                    begin
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        axis_next = axis_reg + 1'b1;
                    end
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (div_done)
                begin
                    gain_next[axis_reg] = div_quot;
                    if (axis_reg == AXIS_Z)
                    begin
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        axis_next  = axis_reg + 1'b1;
                        state_next = ST_SPAN;
                    end
                end
            end
            ST_MUL:
            begin
                // Shift and add, one bit of each magnitude per cycle, MSB first.
                for (int a = 0; a < 3; a++)
                begin
                    acc_next[a] = {acc_reg[a][ACC_W-2:0], 1'b0}
                                + (mag_reg[a][MAG_W-1] ? ACC_W'(gain_reg[a]) : '0);
                    mag_next[a] = {mag_reg[a][MAG_W-2:0], 1'b0};
                end
                if (bit_cnt_reg == '0)
                begin
                    state_next = ST_ROUND;
                end
                else
                begin
                    bit_cnt_next = bit_cnt_reg - 1'b1;
                end
            end
            ST_ROUND:
            begin
                for (int a = 0; a < 3; a++)
                begin
                    res_corr_next[a] = rounded[a][CORR_W-1:0];
                end
                res_sat_next = rounded[0][CORR_W] || rounded[1][CORR_W]
                            || rounded[2][CORR_W];
                state_next   = ST_HEAD_START;
            end
            ST_HEAD_START:
            begin
                cordic_start = 1'b1;
                state_next   = ST_CORDIC;
            end
            ST_CORDIC:
            begin
                if (cordic_done)
                begin
                    res_head_next = cordic_heading;
                    state_next    = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_corr_next  = res_corr_reg;
                    out_head_next  = res_head_reg;
                    out_done_next  = res_done_reg;
                    out_err_next   = res_err_reg;
                    out_sat_next   = res_sat_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and calibration state, with its reset values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cal_count_reg <= CNT_W'(mch_pkg::CAL_COUNT_RESET);
            samples_reg   <= '0;
            out_valid_reg <= 1'b0;
            axis_reg      <= AXIS_X;
            for (int a = 0; a < 3; a++)
            begin
                min_reg[a]    <= '0;
                max_reg[a]    <= '0;
                offset_reg[a] <= '0;
                gain_reg[a]   <= DEFAULT_GAIN;
            end
        end
        else
        begin
            state_reg     <= state_next;
            cal_count_reg <= cal_count_next;
            samples_reg   <= samples_next;
            out_valid_reg <= out_valid_next;
            axis_reg      <= axis_next;
            min_reg       <= min_next;
            max_reg       <= max_next;
            offset_reg    <= offset_next;
            gain_reg      <= gain_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        item_func_reg <= item_func_next;
        item_ok_reg   <= item_ok_next;
        item_v_reg    <= item_v_next;
        mag_reg       <= mag_next;
        neg_reg       <= neg_next;
        acc_reg       <= acc_next;
        bit_cnt_reg   <= bit_cnt_next;
        res_corr_reg  <= res_corr_next;
        res_head_reg  <= res_head_next;
        res_done_reg  <= res_done_next;
        res_err_reg   <= res_err_next;
        res_sat_reg   <= res_sat_next;
        out_corr_reg  <= out_corr_next;
        out_head_reg  <= out_head_next;
        out_done_reg  <= out_done_next;
        out_err_reg   <= out_err_next;
        out_sat_reg   <= out_sat_next;
    end

    // Gain division, one quotient bit per cycle.
    mch_div #(
        .NUM_W (GAIN_W),
        .DEN_W (RAW_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (div_numer),
        .denom (axis_span[RAW_W-1:0]),
        .done  (div_done),
        .quot  (div_quot)
    );

    // Heading from the corrected X and Y axes.
    mch_cordic #(
        .STEPS             (CORDIC_STEPS),
        .HEADING_FRAC_BITS (HEADING_FRAC_BITS),
        .HEAD_W            (HEAD_W)
    ) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cordic_start),
        .x_in    (res_corr_reg[0]),
        .y_in    (res_corr_reg[1]),
        .done    (cordic_done),
        .heading (cordic_heading)
    );

    assign in_stall    = (state_reg != ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign corr_x      = out_corr_reg[0];
    assign corr_y      = out_corr_reg[1];
    assign corr_z      = out_corr_reg[2];
    assign heading_deg = out_head_reg;
    assign cal_done    = out_done_reg;
    assign cal_error   = out_err_reg;
    assign sat_flag    = out_sat_reg;

    // An accepted item is always taken up by the command decode next cycle.
    a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg == ST_EXEC)
        else $error("accepted item did not reach command decode");

    // The divider only finishes while the sequencer waits on it.
    a_div_done_owned: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIVIDE)
        else $error("divider finished outside the divide step");

    // The CORDIC only finishes while the sequencer waits on it.
    a_cordic_done_owned: assert property (@(posedge clk) disable iff (!rst_n)
        cordic_done |-> state_reg == ST_CORDIC)
        else $error("CORDIC finished outside the heading step");

    // A span error is only reported by the sample that completes calibration.
    a_err_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT && res_err_reg |-> res_done_reg)
        else $error("calibration error without calibration done");

    // A saturation flag means at least one axis sits at a limit.
    a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_sat_reg |->
            (out_corr_reg[0] == mch_pkg::CORR_POS_MAX
             || out_corr_reg[0] == mch_pkg::CORR_NEG_MIN
             || out_corr_reg[1] == mch_pkg::CORR_POS_MAX
             || out_corr_reg[1] == mch_pkg::CORR_NEG_MIN
             || out_corr_reg[2] == mch_pkg::CORR_POS_MAX
             || out_corr_reg[2] == mch_pkg::CORR_NEG_MIN))
        else $error("saturation flagged with no axis at a limit");

endmodule

`default_nettype wire

FILE: verif/testbench.sv
// Self-checking testbench for magnetometer_calibrate_heading: a directed table, then random
// calibration rounds and measurements, checked against an in-line predictor of the block.
// Depends on mch_pkg and the block's RTL only.
`default_nettype none

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import mch_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int HEAD_W = $clog2(FULL_TURN << HEADING_FRAC_BITS_DEF);
    localparam logic [ADDR_W-1:0] CAL_COUNT_ADDR = {REG_CAL_SAMPLE_COUNT, 2'b00};
    localparam longint DEFAULT_GAIN =
        ((64'sd1 << GAIN_FRAC_BITS_DEF) + GAIN_DIVISOR / 2) / GAIN_DIVISOR;
    localparam int STALL_LIMIT     = 5000;
    localparam int DRAIN_CYCLES    = 120;
    localparam int NUM_DIRECTED    = 25;
    localparam int ITEMS_PER_PHASE = 90;
    localparam int NUM_PHASES      = 8;
    localparam int REPORT_LIMIT    = 10;

    // One input transfer and one output transfer.
    typedef struct packed {
        logic [FUNC_W-1:0]        func;
        logic                     ok;
        logic signed [RAW_W-1:0]  x;
        logic signed [RAW_W-1:0]  y;
        logic signed [RAW_W-1:0]  z;
    } sample_t;

    typedef struct packed {
        logic signed [CORR_W-1:0] cx;
        logic signed [CORR_W-1:0] cy;
        logic signed [CORR_W-1:0] cz;
        logic [HEAD_W-1:0]        hdg;
        logic                     done;
        logic                     err;
        logic                     sat;
    } reading_t;

    // A row of the directed table: either a register write or a sample.
    typedef struct {
        bit      is_cfg;
        int      count;
        sample_t s;
        bit      zero_expected;
    } stim_row_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [ADDR_W-1:0]        paddr = '0;
    logic [DATA_W-1:0]        pwdata = '0;
    logic [DATA_W-1:0]        prdata;
    logic                     pready;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic [FUNC_W-1:0]        func = '0;
    logic                     read_ok = 1'b0;
    logic signed [RAW_W-1:0]  raw_x = '0;
    logic signed [RAW_W-1:0]  raw_z = '0;
    logic signed [RAW_W-1:0]  raw_y = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic signed [CORR_W-1:0] corr_x;
    logic signed [CORR_W-1:0] corr_y;
    logic signed [CORR_W-1:0] corr_z;
    logic [HEAD_W-1:0]        heading_deg;
    logic                     cal_done;
    logic                     cal_error;
    logic                     sat_flag;

    magnetometer_calibrate_heading DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .read_ok     (read_ok),
        .raw_x       (raw_x),
        .raw_z       (raw_z),
        .raw_y       (raw_y),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .corr_x      (corr_x),
        .corr_y      (corr_y),
        .corr_z      (corr_z),
        .heading_deg (heading_deg),
        .cal_done    (cal_done),
        .cal_error   (cal_error),
        .sat_flag    (sat_flag)
    );

    // Clock with a 4 ns period.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // atan(2^-i) in degrees with sixteen fraction bits.
    longint atan_step_deg [0:23] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    // Predicted calibration state and the programmed round length.
    logic signed [RAW_W-1:0] axis_lo [3];
    logic signed [RAW_W-1:0] axis_hi [3];
    logic signed [RAW_W-1:0] axis_centre [3];
    logic [31:0]             axis_scale [3];
    logic [CNT_W-1:0]        samples_in_round;
    logic [CNT_W-1:0]        round_length;

    reading_t readings_due [$];
    int       mismatches = 0;
    int       idle_cycles = 0;
    int       burst_left = 4;
    int       n_samples = 0;
    int       n_readings = 0;
    int       n_completions = 0;
    int       n_flat = 0;
    int       n_saturated = 0;
    int       n_writes = 0;
    int       stall_mode = 0;
    int       stall_left = 0;

    // Advance the predicted state by one sample and return the reading it produces.
    function automatic reading_t step_calibration(input sample_t s);
        reading_t r;
        longint   v [3];
        longint   corr [3];
        longint   diff, mag, q, span, x, y, z, dx, dy, t, h;
        int       sh, hs, a, i;
        r = '0;
        corr = '{0, 0, 0};
        v[0] = s.ok ? longint'(s.x) : 0;
        v[1] = s.ok ? longint'(s.y) : 0;
        v[2] = s.ok ? longint'(s.z) : 0;
        case (s.func)
            FUNC_START:
            begin
                samples_in_round = '0;
                for (a = 0; a < 3; a++)
                begin
                    axis_lo[a] = '0;
                    axis_hi[a] = '0;
                    axis_centre[a] = '0;
                    axis_scale[a] = DEFAULT_GAIN[31:0];
                end
            end
            FUNC_CAL:
            begin
                for (a = 0; a < 3; a++)
                begin
                    if (samples_in_round == 0 || v[a] < longint'(axis_lo[a]))
                        axis_lo[a] = v[a][RAW_W-1:0];
                    if (samples_in_round == 0 || v[a] > longint'(axis_hi[a]))
                        axis_hi[a] = v[a][RAW_W-1:0];
                end
                samples_in_round = samples_in_round + 1'b1;
                // The round closes on reaching the length, or on wrapping past it.
                if (samples_in_round >= round_length || samples_in_round == 0)
                begin
                    r.done = 1'b1;
                    samples_in_round = '0;
                    for (a = 0; a < 3; a++)
                    begin
                        span = longint'(axis_hi[a]) - longint'(axis_lo[a]);
                        t = (longint'(axis_hi[a]) + longint'(axis_lo[a])) >>> 1;
                        axis_centre[a] = t[RAW_W-1:0];
                        if (span == 0)
                            r.err = 1'b1;
                        else
                        begin
                            q = ((64'sd2 << GAIN_FRAC_BITS_DEF) + span / 2) / span;
                            axis_scale[a] = q[31:0];
                        end
                    end
                end
            end
            FUNC_MEASURE:
            begin
                if (s.ok)
                begin
                    // Offset removal and gain, rounded half away from zero, then saturated.
                    sh = GAIN_FRAC_BITS_DEF - CORR_FRAC;
                    for (a = 0; a < 3; a++)
                    begin
                        diff = v[a] - longint'(axis_centre[a]);
                        mag = (diff < 0 ? -diff : diff) * longint'(axis_scale[a]);
                        q = (mag + (64'sd1 << (sh - 1))) >>> sh;
                        if (diff < 0)
                        begin
                            if (q > 131072)
                            begin
                                r.sat = 1'b1;
                                corr[a] = -131072;
                            end
                            else
                                corr[a] = -q;
                        end
                        else if (q > 131071)
                        begin
                            r.sat = 1'b1;
                            corr[a] = 131071;
                        end
                        else
                            corr[a] = q;
                    end
                    // Vectoring CORDIC on the corrected X and Y; a zero vector gives zero.
                    if (corr[0] != 0 || corr[1] != 0)
                    begin
                        x = corr[0] << PRESCALE_BITS;
                        y = corr[1] << PRESCALE_BITS;
                        z = 0;
                        if (x < 0)
                        begin
                            t = x;
                            if (y >= 0)
                            begin
                                x = y;
                                y = -t;
                                z = longint'(QUARTER_TURN) << ANG_FRAC;
                            end
                            else
                            begin
                                x = -y;
                                y = t;
                                z = -(longint'(QUARTER_TURN) << ANG_FRAC);
                            end
                        end
                        for (i = 0; i < CORDIC_STEPS_DEF && i < 24; i++)
                        begin
                            dx = y >>> i;
                            dy = x >>> i;
                            if (y > 0)
                            begin
                                x = x + dx;
                                y = y - dy;
                                z = z + atan_step_deg[i];
                            end
                            else
                            begin
                                x = x - dx;
                                y = y + dy;
                                z = z - atan_step_deg[i];
                            end
                        end
                        if (z < 0)
                            z = z + (longint'(FULL_TURN) << ANG_FRAC);
                        if (z < 0)
                            z = 0;
                        h = z;
                        hs = ANG_FRAC - HEADING_FRAC_BITS_DEF;
                        if (hs > 0)
                            h = (h + (64'sd1 << (hs - 1))) >>> hs;
                        // A heading that rounds up to a full turn wraps to zero.
                        if (h >= (longint'(FULL_TURN) << HEADING_FRAC_BITS_DEF))
                            h = h - (longint'(FULL_TURN) << HEADING_FRAC_BITS_DEF);
                        r.hdg = h[HEAD_W-1:0];
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.cx = corr[0][CORR_W-1:0];
        r.cy = corr[1][CORR_W-1:0];
        r.cz = corr[2][CORR_W-1:0];
        return r;
    endfunction

    function automatic stim_row_t sample_row(input logic [FUNC_W-1:0] f, input logic ok,
                                             input int x, input int y, input int z,
                                             input bit zero_expected);
        stim_row_t row;
        row.is_cfg = 1'b0;
        row.count = 0;
        row.s.func = f;
        row.s.ok = ok;
        row.s.x = x[RAW_W-1:0];
        row.s.y = y[RAW_W-1:0];
        row.s.z = z[RAW_W-1:0];
        row.zero_expected = zero_expected;
        return row;
    endfunction

    function automatic stim_row_t config_row(input int count);
        stim_row_t row;
        row.is_cfg = 1'b1;
        row.count = count;
        row.s = '0;
        row.zero_expected = 1'b0;
        return row;
    endfunction

    // Axis counts: full range, extremes, near zero and mid-range.
    function automatic logic signed [RAW_W-1:0] pick_raw();
        int v;
        case ($urandom_range(0, 5))
            0: v = $urandom;
            1:
            begin
                case ($urandom_range(0, 4))
                    0: v = -32768;
                    1: v = 32767;
                    2: v = -1;
                    3: v = 0;
                    default: v = 1;
                endcase
            end
            2: v = int'($urandom_range(0, 100)) - 50;
            3: v = int'($urandom_range(0, 4000)) - 2000;
            default: v = $urandom;
        endcase
        return v[RAW_W-1:0];
    endfunction

    function automatic sample_t random_sample(input logic [FUNC_W-1:0] f, input int ok_pct);
        sample_t s;
        s.func = f;
        s.ok = ($urandom_range(0, 99) < ok_pct);
        s.x = pick_raw();
        s.y = pick_raw();
        s.z = pick_raw();
        return s;
    endfunction

    // Present one sample from a falling edge and hold it until the transfer. Returns
    // at a falling edge, with valid still high only when the burst goes on.
    task automatic send_sample(input sample_t s, input bit zero_expected);
        reading_t want;
        int       gap;
        func = s.func;
        read_ok = s.ok;
        raw_x = s.x;
        raw_y = s.y;
        raw_z = s.z;
        in_valid = 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        want = step_calibration(s);
        if (zero_expected)
            want = '0;
        readings_due.push_back(want);
        n_samples++;
        @(negedge clk);
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 6);
            if ($urandom_range(0, 5) == 0)
                burst_left = $urandom_range(30, 80);
            else
                burst_left = $urandom_range(0, 8);
            in_valid = 1'b0;
            repeat (gap - 1)
                @(negedge clk);
        end
        else
            burst_left--;
    endtask

    // Write the round length once the block has drained, then read it back.
    task automatic write_round_length(input int count);
        in_valid = 1'b0;
        while (readings_due.size() != 0)
            @(negedge clk);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = CAL_COUNT_ADDR;
        pwdata = DATA_W'(count[CNT_W-1:0]);
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        round_length = count[CNT_W-1:0];
        n_writes++;
        pwrite = 1'b0;
        penable = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        if (prdata !== DATA_W'(round_length))
        begin
            if (mismatches < REPORT_LIMIT)
                $display("[%0t] register read back %0d, expected %0d", $realtime, prdata,
                         round_length);
            mismatches++;
        end
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    // Receiver stall pattern: free running, light, heavy and solid stretches.
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = (stall_mode == 3) ? $urandom_range(1, 20) : $urandom_range(10, 150);
        end
        else
            stall_left = stall_left - 1;
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 9) < 3);
            2: out_stall <= ($urandom_range(0, 9) < 7);
            default: out_stall <= 1'b1;
        endcase
    end

    // Check every output transfer against the oldest predicted reading; watchdog.
    always @(posedge clk)
    begin
        reading_t got;
        reading_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                got.cx = corr_x;
                got.cy = corr_y;
                got.cz = corr_z;
                got.hdg = heading_deg;
                got.done = cal_done;
                got.err = cal_error;
                got.sat = sat_flag;
                n_readings++;
                if (got.done)
                    n_completions++;
                if (got.err)
                    n_flat++;
                if (got.sat)
                    n_saturated++;
                if (readings_due.size() == 0)
                begin
                    if (mismatches < REPORT_LIMIT)
                        $display("[%0t] reading with none outstanding: %p", $realtime, got);
                    mismatches++;
                end
                else
                begin
                    want = readings_due.pop_front();
                    if (got.cx !== want.cx || got.cy !== want.cy || got.cz !== want.cz ||
                        got.hdg !== want.hdg || got.done !== want.done ||
                        got.err !== want.err || got.sat !== want.sat)
                    begin
                        if (mismatches < REPORT_LIMIT)
                            $display("[%0t] reading mismatch: expected %p, got %p",
                                     $realtime, want, got);
                        mismatches++;
                    end
                end
            end
            if ((out_valid && !out_stall) || (in_valid && !in_stall))
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Timed out with %0d readings outstanding", readings_due.size());
                $display("FAIL");
                $finish;
            end
        end
    end

    // Stimulus: directed table, then random phases each with its own round length.
    initial
    begin
        stim_row_t directed [NUM_DIRECTED];
        int        phase_counts [NUM_PHASES];
        int        ph, issued, kind, n_cal, n_meas, k, a;
        bit [2:0]  flat_axes;
        sample_t   s;
        logic signed [RAW_W-1:0] flat_val [3];

        samples_in_round = '0;
        round_length = CAL_COUNT_RESET[CNT_W-1:0];
        for (a = 0; a < 3; a++)
        begin
            axis_lo[a] = '0;
            axis_hi[a] = '0;
            axis_centre[a] = '0;
            axis_scale[a] = DEFAULT_GAIN[31:0];
        end

        directed = '{
            // Reset state: zero vector, then gauss-scaled readings.
            sample_row(FUNC_MEASURE, 1'b1, 0, 0, 0, 1'b1),
            sample_row(FUNC_MEASURE, 1'b1, 32767, -32768, -32768, 1'b0),
            sample_row(FUNC_MEASURE, 1'b1, -1090, 1090, 1, 1'b0),
            // Failed read, unused command and start all give an empty reading.
            sample_row(FUNC_MEASURE, 1'b0, -32768, 32767, 12345, 1'b1),
            sample_row(FUNC_UNUSED, 1'b1, 32767, 32767, 32767, 1'b1),
            sample_row(FUNC_START, 1'b1, -32768, -32768, -32768, 1'b1),
            // Full-range round with a flat Z axis, then headings in the second, third and fourth quadrants.
            config_row(2),
            sample_row(FUNC_CAL, 1'b1, -32768, 32767, 100, 1'b0),
            sample_row(FUNC_CAL, 1'b1, 32767, -32768, 100, 1'b0),
            sample_row(FUNC_MEASURE, 1'b1, 32767, -2, -32768, 1'b0),
            sample_row(FUNC_MEASURE, 1'b1, -20000, 5000, 0, 1'b0),
            sample_row(FUNC_MEASURE, 1'b1, -20000, -5000, 0, 1'b0),
            sample_row(FUNC_MEASURE, 1'b1, 0, -32768, 0, 1'b0),
            // A failed read still enters the round as zeros.
            config_row(1),
            sample_row(FUNC_CAL, 1'b0, 1234, 1234, 1234, 1'b0),
            // Span of one count: the largest gain, so a full-scale measurement saturates.
            config_row(2),
            sample_row(FUNC_CAL, 1'b1, 0, 0, 5, 1'b0),
            sample_row(FUNC_CAL, 1'b1, 1, 1, 6, 1'b0),
            sample_row(FUNC_MEASURE, 1'b1, 32767, -32768, -32768, 1'b0),
            sample_row(FUNC_MEASURE, 1'b1, 1, 0, 6, 1'b0),
            // A round length of zero closes a round on every sample.
            config_row(0),
            sample_row(FUNC_CAL, 1'b1, -5, 7, 9, 1'b0),
            sample_row(FUNC_MEASURE, 1'b1, -5, 8, 9, 1'b0),
            sample_row(FUNC_START, 1'b1, 0, 0, 0, 1'b1),
            sample_row(FUNC_MEASURE, 1'b1, 1090, -1090, 0, 1'b0)
        };

        phase_counts = '{1, 4, 65535, 0, 3, $urandom_range(5, 30), 2, 12};

        // Reset, released at a falling edge.
        repeat (2)
            @(negedge clk);
        rst_n = 1'b1;

        foreach (directed[r])
        begin
            if (directed[r].is_cfg)
                write_round_length(directed[r].count);
            else
                send_sample(directed[r].s, directed[r].zero_expected);
        end

        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            write_round_length(phase_counts[ph]);
            issued = 0;
            while (issued < ITEMS_PER_PHASE)
            begin
                kind = $urandom_range(0, 9);
                if (kind <= 6)
                begin
                    // A calibration round, sometimes one short or one over, then readings.
                    if ($urandom_range(0, 9) != 0)
                    begin
                        send_sample(random_sample(FUNC_START, 100), 1'b0);
                        issued++;
                    end
                    if (phase_counts[ph] == 0 || phase_counts[ph] > 40)
                        n_cal = $urandom_range(1, 6);
                    else
                    begin
                        n_cal = phase_counts[ph];
                        case ($urandom_range(0, 7))
                            0: n_cal = (n_cal > 1) ? n_cal - 1 : n_cal;
                            1: n_cal = n_cal + 1;
                            default: ;
                        endcase
                    end
                    flat_axes = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(1, 7)) : 3'b000;
                    for (a = 0; a < 3; a++)
                        flat_val[a] = pick_raw();
                    for (k = 0; k < n_cal; k++)
                    begin
                        s = random_sample(FUNC_CAL, 95);
                        if (flat_axes[0])
                            s.x = flat_val[0];
                        if (flat_axes[1])
                            s.y = flat_val[1];
                        if (flat_axes[2])
                            s.z = flat_val[2];
                        send_sample(s, 1'b0);
                        issued++;
                    end
                    n_meas = $urandom_range(1, 5);
                    for (k = 0; k < n_meas; k++)
                    begin
                        send_sample(random_sample(FUNC_MEASURE, 90), 1'b0);
                        issued++;
                    end
                end
                else
                begin
                    // Noise: any command, any read status.
                    n_meas = $urandom_range(1, 4);
                    for (k = 0; k < n_meas; k++)
                    begin
                        send_sample(random_sample(2'($urandom_range(0, 3)), 50), 1'b0);
                        issued++;
                    end
                end
            end
        end

        // Drain, then allow for any stray reading.
        in_valid = 1'b0;
        while (readings_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES)
            @(negedge clk);

        $display("Covered %0d samples and %0d readings over %0d register writes.",
                 n_samples, n_readings, n_writes);
        $display("Calibrations completed: %0d (%0d with a flat axis); saturated readings: %0d.",
                 n_completions, n_flat, n_saturated);
        if (mismatches == 0 && readings_due.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
